@@ sv/qrmpw_pkg.sv @@
// Package with the shared constants, codes and control structs of the placement walker.
`timescale 1ns / 1ps
`default_nettype none
package qrmpw_pkg;

  localparam int unsigned MAX_WIDTH = 177;
  localparam int unsigned MIN_WIDTH = 21;
  localparam int unsigned MAP_DEPTH = MAX_WIDTH * MAX_WIDTH;
  localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH);

  localparam int unsigned TIMING_COL         = 6;
  localparam int unsigned TOP_RESUME_ROW     = 9;
  localparam int unsigned BOTTOM_RESUME_BACK = 8;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_STEP    = 2'd2;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_LEFT  = 2'd1;
  localparam logic [1:0] PH_RIGHT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  typedef struct packed {
    logic clear_en;
    logic wr_load;
    logic wr_commit;
    logic restart;
    logic move_step;
    logic read_en;
    logic emit_zero;
    logic emit_corner;
    logic emit_pos;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
    logic not_started;
    logic exhausted;
    logic move_out;
    logic map_free;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/qrmpw_intf.sv @@
// Channel interfaces for requests, results and the width register of the placement walker.
`timescale 1ns / 1ps
`default_nettype none
interface qrmpw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] col;
  logic [7:0] row;
  logic       reserved_flag;

  modport source (output valid, command, col, row, reserved_flag, input ready);
  modport sink (input valid, command, col, row, reserved_flag, output ready);
endinterface

interface qrmpw_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_col;
  logic [7:0] out_row;
  logic       position_valid;

  modport source (output valid, out_col, out_row, position_valid, input ready);
  modport sink (input valid, out_col, out_row, position_valid, output ready);
endinterface

interface qrmpw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_width;

  modport source (output valid, symbol_width, input ready);
  modport sink (input valid, symbol_width, output ready);
endinterface
`default_nettype wire

@@ sv/qr_module_placement_walker.sv @@
// Top level of the QR module placement walker.
//
//   Channel  Direction  Contents
//   req_i    in         command, col, row, reserved_flag
//   rsp_o    out        out_col, out_row, position_valid
//   cfg_i    in         symbol_width
//
// After reset the reserved map is cleared one module per cycle, over all MAP_DEPTH addresses;
// no request is taken until then, while width writes are taken at any time.
// A write request is loaded, then committed in the write state; a restart, or a step that gives
// the corner or finds the walk already exhausted, is done as it is taken. Other steps run the
// move (address), read (map read) and check states per module examined; off the grid, move ends it.
// A result waits in the output register; the next request is taken as that result leaves.
`timescale 1ns / 1ps
`default_nettype none
module qr_module_placement_walker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qrmpw_req_if.sink   req_i,
  qrmpw_rsp_if.source rsp_o,
  qrmpw_cfg_if.sink   cfg_i
);

  qrmpw_pkg::cmd_t cmd;
  qrmpw_pkg::sts_t sts;
  logic            cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  qrmpw_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_command_i (req_i.command),
    .req_ready_o   (req_i.ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  qrmpw_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .col_i           (req_i.col),
    .row_i           (req_i.row),
    .reserved_flag_i (req_i.reserved_flag),
    .cfg_valid_i     (cfg_we),
    .cfg_width_i     (cfg_i.symbol_width),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_col_o       (rsp_o.out_col),
    .rsp_row_o       (rsp_o.out_row),
    .rsp_pos_valid_o (rsp_o.position_valid)
  );

endmodule
`default_nettype wire

@@ sv/qrmpw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module qrmpw_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/qrmpw_ctrl.sv @@
// Controller state machine that sequences map clearing, flag writes and walk steps.
`timescale 1ns / 1ps
`default_nettype none
module qrmpw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  input  wire logic [1:0]    req_command_i,
  output logic               req_ready_o,
  input  wire qrmpw_pkg::sts_t sts_i,
  output qrmpw_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_MOVE  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       accept;

  assign req_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req_command_i)
            qrmpw_pkg::CMD_WRITE: begin
              cmd_o.wr_load = 1'b1;
              state_d       = ST_WRITE;
            end
            qrmpw_pkg::CMD_RESTART: begin
              cmd_o.restart = 1'b1;
            end
            qrmpw_pkg::CMD_STEP: begin
              if (sts_i.exhausted) begin
                cmd_o.emit_zero = 1'b1;
              end else if (sts_i.not_started) begin
                cmd_o.emit_corner = 1'b1;
              end else begin
                state_d = ST_MOVE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WRITE: begin
        cmd_o.wr_commit = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_MOVE: begin
        cmd_o.move_step = 1'b1;
        if (sts_i.move_out) begin
          cmd_o.emit_zero = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read_en = 1'b1;
        state_d       = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.map_free) begin
          cmd_o.emit_pos = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_MOVE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/qrmpw_dpath.sv @@
// Datapath with the walk position, the reserved map, the width register and the result register.
`timescale 1ns / 1ps
`default_nettype none
module qrmpw_dpath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire qrmpw_pkg::cmd_t cmd_i,
  output qrmpw_pkg::sts_t      sts_o,
  input  wire logic [7:0]      col_i,
  input  wire logic [7:0]      row_i,
  input  wire logic            reserved_flag_i,
  input  wire logic            cfg_valid_i,
  input  wire logic [7:0]      cfg_width_i,
  output logic                 rsp_valid_o,
  input  wire logic            rsp_ready_i,
  output logic [7:0]           rsp_col_o,
  output logic [7:0]           rsp_row_o,
  output logic                 rsp_pos_valid_o
);

  localparam int unsigned AW = qrmpw_pkg::MAP_AW;

  logic [7:0]    width_q;
  logic [7:0]    cur_col_q;
  logic [7:0]    cur_row_q;
  logic          up_q;
  logic [1:0]    phase_q;
  logic [AW-1:0] clr_cnt_q;
  logic          out_valid_q;
  logic [7:0]    out_col_q;
  logic [7:0]    out_row_q;
  logic          out_pos_q;
  logic [AW-1:0] rd_addr_q;
  logic [AW-1:0] wr_addr_q;
  logic          wr_flag_q;
  logic          wr_ok_q;

  logic [7:0]       cfg_width_clamped;
  logic signed [9:0] wq;
  logic signed [9:0] nx;
  logic signed [9:0] ny;
  logic             nup;
  logic [1:0]       nph;
  logic             move_out;
  logic [AW-1:0]    cand_addr;
  logic [AW-1:0]    req_addr;
  logic             req_in_map;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_wdata;
  logic             ram_rdata;
  logic             emit;

  always_comb begin
    if (cfg_width_i < 8'(qrmpw_pkg::MIN_WIDTH)) begin
      cfg_width_clamped = 8'(qrmpw_pkg::MIN_WIDTH);
    end else if (cfg_width_i > 8'(qrmpw_pkg::MAX_WIDTH)) begin
      cfg_width_clamped = 8'(qrmpw_pkg::MAX_WIDTH);
    end else begin
      cfg_width_clamped = cfg_width_i;
    end
  end

  // One move of the zigzag, including the turns at the edges and the timing column.
  always_comb begin
    wq  = $signed({2'b00, width_q});
    nup = up_q;
    if (phase_q == qrmpw_pkg::PH_LEFT) begin
      nx  = $signed({2'b00, cur_col_q}) - 10'sd1;
      ny  = $signed({2'b00, cur_row_q});
      nph = qrmpw_pkg::PH_RIGHT;
    end else begin
      nx  = $signed({2'b00, cur_col_q}) + 10'sd1;
      ny  = up_q ? $signed({2'b00, cur_row_q}) - 10'sd1
                 : $signed({2'b00, cur_row_q}) + 10'sd1;
      nph = qrmpw_pkg::PH_LEFT;
    end
    if (up_q) begin
      if (ny < 10'sd0) begin
        ny  = 10'sd0;
        nx  = nx - 10'sd2;
        nup = 1'b0;
        if (nx == 10'(qrmpw_pkg::TIMING_COL)) begin
          nx = nx - 10'sd1;
          ny = 10'(qrmpw_pkg::TOP_RESUME_ROW);
        end
      end
    end else begin
      if (ny >= wq) begin
        ny  = wq - 10'sd1;
        nx  = nx - 10'sd2;
        nup = 1'b1;
        if (nx == 10'(qrmpw_pkg::TIMING_COL)) begin
          nx = nx - 10'sd1;
          ny = ny - 10'(qrmpw_pkg::BOTTOM_RESUME_BACK);
        end
      end
    end
    move_out = (nx < 10'sd0) || (ny < 10'sd0) || (nx >= wq) || (ny >= wq);
  end

  assign cand_addr  = AW'(ny[7:0] * 16'(qrmpw_pkg::MAX_WIDTH)) + AW'(nx[7:0]);
  assign req_addr   = AW'(row_i * 16'(qrmpw_pkg::MAX_WIDTH)) + AW'(col_i);
  assign req_in_map = (col_i < 8'(qrmpw_pkg::MAX_WIDTH)) && (row_i < 8'(qrmpw_pkg::MAX_WIDTH));

  assign ram_we    = cmd_i.clear_en || (cmd_i.wr_commit && wr_ok_q);
  assign ram_waddr = cmd_i.clear_en ? clr_cnt_q : wr_addr_q;
  assign ram_wdata = cmd_i.clear_en ? 1'b0 : wr_flag_q;

  qrmpw_ram #(
    .WIDTH (1),
    .DEPTH (qrmpw_pkg::MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.read_en),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  assign emit = cmd_i.emit_zero || cmd_i.emit_corner || cmd_i.emit_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 8'(qrmpw_pkg::MIN_WIDTH);
      cur_col_q   <= 8'(qrmpw_pkg::MIN_WIDTH - 1);
      cur_row_q   <= 8'(qrmpw_pkg::MIN_WIDTH - 1);
      up_q        <= 1'b1;
      phase_q     <= qrmpw_pkg::PH_START;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_en) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.emit_corner) begin
        phase_q <= qrmpw_pkg::PH_LEFT;
      end
      if (cmd_i.move_step) begin
        up_q <= nup;
        if (move_out) begin
          phase_q <= qrmpw_pkg::PH_DONE;
        end else begin
          phase_q   <= nph;
          cur_col_q <= nx[7:0];
          cur_row_q <= ny[7:0];
        end
      end
      if (cmd_i.restart) begin
        cur_col_q <= width_q - 8'd1;
        cur_row_q <= width_q - 8'd1;
        up_q      <= 1'b1;
        phase_q   <= qrmpw_pkg::PH_START;
      end
      if (cfg_valid_i) begin
        width_q   <= cfg_width_clamped;
        cur_col_q <= cfg_width_clamped - 8'd1;
        cur_row_q <= cfg_width_clamped - 8'd1;
        up_q      <= 1'b1;
        phase_q   <= qrmpw_pkg::PH_START;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_load) begin
      wr_addr_q <= req_addr;
      wr_flag_q <= reserved_flag_i;
      wr_ok_q   <= req_in_map;
    end
    if (cmd_i.move_step) begin
      rd_addr_q <= cand_addr;
    end
    if (cmd_i.emit_zero) begin
      out_col_q <= 8'd0;
      out_row_q <= 8'd0;
      out_pos_q <= 1'b0;
    end else if (cmd_i.emit_corner || cmd_i.emit_pos) begin
      out_col_q <= cur_col_q;
      out_row_q <= cur_row_q;
      out_pos_q <= 1'b1;
    end
  end

  assign sts_o.clear_last  = (clr_cnt_q == AW'(qrmpw_pkg::MAP_DEPTH - 1));
  assign sts_o.out_free    = !out_valid_q || rsp_ready_i;
  assign sts_o.not_started = (phase_q == qrmpw_pkg::PH_START);
  assign sts_o.exhausted   = (phase_q == qrmpw_pkg::PH_DONE);
  assign sts_o.move_out    = move_out;
  assign sts_o.map_free    = !ram_rdata;

  assign rsp_valid_o     = out_valid_q;
  assign rsp_col_o       = out_col_q;
  assign rsp_row_o       = out_row_q;
  assign rsp_pos_valid_o = out_pos_q;

endmodule
`default_nettype wire
